FILE: src/pcm16_segment_level_qc_assert.svh
// Assertion macros used by the top level of the level meter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef PCM16_SEGMENT_LEVEL_QC_ASSERT_SVH
`define PCM16_SEGMENT_LEVEL_QC_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define PSLQC_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define PSLQC_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: src/pslqc_pkg.sv
// Package for the PCM16 segment level meter: widths, register indexes and
// the structs passed between the stages. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pslqc_pkg;

	localparam int SMP_W   = 16;
	localparam int RATE_W  = 19;
	localparam int CH_W    = 4;
	localparam int SQ_W    = 31;
	localparam int CLIP_W  = 25;
	localparam int EN_W    = 54;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SILENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWPK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 2'd2;

	localparam logic [CFG_W-1:0] SILENT_RST = 16'd32;
	localparam logic [CFG_W-1:0] LOWPK_RST  = 16'd700;
	localparam logic [CFG_W-1:0] CLIP_RST   = 16'd32760;

	// One sample after the first stage.
	typedef struct packed {
		logic [SMP_W-1:0]  mag;
		logic [SQ_W-1:0]   sq;
		logic              clip;
		logic              last;
		logic [RATE_W-1:0] rate;
		logic [CH_W-1:0]   chans;
	} beat_t;

	// Segment figures including the current sample.
	typedef struct packed {
		logic [SMP_W-1:0]  peak;
		logic [CLIP_W-1:0] clips;
		logic [EN_W-1:0]   energy;
	} fig_t;

	// Stage control from the top level.
	typedef struct packed {
		logic adv;
		logic report;
	} ctl_t;

	typedef struct packed {
		logic [SMP_W-1:0]  segment_peak;
		logic [CLIP_W-1:0] segment_clipped_samples;
		logic [EN_W-1:0]   segment_energy;
		logic              is_silent;
		logic              is_low_peak;
		logic              has_clipping;
		logic              fmt_mismatch;
		logic [SMP_W-1:0]  total_peak;
		logic [CNT_W-1:0]  total_bad_segments;
		logic [CNT_W-1:0]  total_silent_segments;
		logic [CNT_W-1:0]  total_low_peak_segments;
		logic [CNT_W-1:0]  total_clipped_segments;
	} res_t;

	// Saturating increment of a segment total.
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic en);
		logic [CNT_W-1:0] r;
		r = c;
		if (en && (c != {CNT_W{1'b1}})) begin
			r = c + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/pslqc_front.sv
// Input stage: magnitude, square and clip test of each sample, registered.
// Uses pslqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pslqc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic                        adv,
	input  wire logic [pslqc_pkg::SMP_W-1:0]  sample,
	input  wire logic                        last_in_segment,
	input  wire logic [pslqc_pkg::RATE_W-1:0] seg_rate,
	input  wire logic [pslqc_pkg::CH_W-1:0]   channels,
	input  wire logic [pslqc_pkg::CFG_W-1:0]  clip_thr,
	output      pslqc_pkg::beat_t            beat_s1,
	output      logic                        valid_s1
);
	import pslqc_pkg::*;

	logic [SMP_W-1:0]   mag;
	logic [2*SMP_W-1:0] prod;

	// The most negative sample wraps to 0x8000, which is its true magnitude.
	assign mag  = sample[SMP_W-1] ? (~sample + 1'b1) : sample;
	assign prod = {{SMP_W{1'b0}}, mag} * {{SMP_W{1'b0}}, mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.mag   <= mag;
			beat_s1.sq    <= prod[SQ_W-1:0];
			beat_s1.clip  <= (mag >= clip_thr);
			beat_s1.last  <= last_in_segment;
			beat_s1.rate  <= seg_rate;
			beat_s1.chans <= channels;
		end
	end

endmodule

`default_nettype wire

FILE: src/pslqc_seg.sv
// Segment accumulators: peak, clip count and saturating energy.
// Uses pslqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pslqc_seg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pslqc_pkg::ctl_t  ctl,
	input  wire pslqc_pkg::beat_t beat,
	output      pslqc_pkg::fig_t  fig_n
);
	import pslqc_pkg::*;

	logic [SMP_W-1:0]  peak_q;
	logic [CLIP_W-1:0] clips_q;
	logic [EN_W-1:0]   energy_q;
	logic [EN_W:0]     esum;

	assign esum = {1'b0, energy_q} + (EN_W+1)'(beat.sq);

	always_comb begin
		fig_n.peak   = (beat.mag > peak_q) ? beat.mag : peak_q;
		fig_n.clips  = (beat.clip && (clips_q != {CLIP_W{1'b1}})) ? clips_q + 1'b1 : clips_q;
		fig_n.energy = esum[EN_W] ? {EN_W{1'b1}} : esum[EN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q   <= '0;
			clips_q  <= '0;
			energy_q <= '0;
		end else if (ctl.report) begin
			peak_q   <= '0;
			clips_q  <= '0;
			energy_q <= '0;
		end else if (ctl.adv) begin
			peak_q   <= fig_n.peak;
			clips_q  <= fig_n.clips;
			energy_q <= fig_n.energy;
		end
	end

endmodule

`default_nettype wire

FILE: src/pslqc_report.sv
// Result stage: format check, classification, running totals and the
// output register. Uses pslqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pslqc_report (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pslqc_pkg::ctl_t             ctl,
	input  wire pslqc_pkg::fig_t             fig_n,
	input  wire logic [pslqc_pkg::RATE_W-1:0] rate,
	input  wire logic [pslqc_pkg::CH_W-1:0]   chans,
	input  wire logic [pslqc_pkg::CFG_W-1:0]  silent_thr,
	input  wire logic [pslqc_pkg::CFG_W-1:0]  low_thr,
	input  wire logic                        out_stall,
	output      logic                        out_valid,
	output      pslqc_pkg::res_t             res_q
);
	import pslqc_pkg::*;

	logic [RATE_W-1:0] exp_rate_q;
	logic [CH_W-1:0]   exp_ch_q;
	logic [SMP_W-1:0]  top_peak_q;
	logic [CNT_W-1:0]  bad_q;
	logic [CNT_W-1:0]  silent_q;
	logic [CNT_W-1:0]  lowpk_q;
	logic [CNT_W-1:0]  clipped_q;

	logic [RATE_W-1:0] rate_ref;
	logic [CH_W-1:0]   ch_ref;
	logic              mismatch;
	logic              silent;
	logic              lowp;
	logic              clipped;
	logic [SMP_W-1:0]  top_peak_n;

	// An unknown format takes the ending segment's own, so it matches.
	assign rate_ref   = (exp_rate_q != '0) ? exp_rate_q : rate;
	assign ch_ref     = (exp_rate_q != '0) ? exp_ch_q : chans;
	assign mismatch   = (rate != rate_ref) || (chans != ch_ref);
	assign silent     = (fig_n.peak <= silent_thr);
	assign lowp       = !silent && (fig_n.peak < low_thr);
	assign clipped    = (fig_n.clips != '0);
	assign top_peak_n = (fig_n.peak > top_peak_q) ? fig_n.peak : top_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			exp_rate_q <= '0;
			exp_ch_q   <= '0;
			top_peak_q <= '0;
			bad_q      <= '0;
			silent_q   <= '0;
			lowpk_q    <= '0;
			clipped_q  <= '0;
		end else if (ctl.report) begin
			out_valid  <= 1'b1;
			exp_rate_q <= rate_ref;
			exp_ch_q   <= ch_ref;
			top_peak_q <= top_peak_n;
			bad_q      <= bump(bad_q, mismatch);
			silent_q   <= bump(silent_q, silent);
			lowpk_q    <= bump(lowpk_q, lowp);
			clipped_q  <= bump(clipped_q, clipped);
		end else if (out_valid && !out_stall) begin
			out_valid  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.report) begin
			res_q.segment_peak            <= fig_n.peak;
			res_q.segment_clipped_samples <= fig_n.clips;
			res_q.segment_energy          <= fig_n.energy;
			res_q.is_silent               <= silent;
			res_q.is_low_peak             <= lowp;
			res_q.has_clipping            <= clipped;
			res_q.fmt_mismatch            <= mismatch;
			res_q.total_peak              <= top_peak_n;
			res_q.total_bad_segments      <= bump(bad_q, mismatch);
			res_q.total_silent_segments   <= bump(silent_q, silent);
			res_q.total_low_peak_segments <= bump(lowpk_q, lowp);
			res_q.total_clipped_segments  <= bump(clipped_q, clipped);
		end
	end

endmodule

`default_nettype wire

FILE: src/pcm16_segment_level_qc.sv
// Top level of the PCM16 segment level meter and quality check.
// Uses pslqc_pkg, pslqc_front, pslqc_seg, pslqc_report and the assertion header.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ---------------------------------------------
//   input    in_valid / in_stall   sample, last_in_segment, seg_rate, channels
//   output   out_valid / out_stall segment figures, flags and running totals
//   config   wr_en                 wr_index, wr_data
//
// One beat can be taken in every clock cycle while in_stall is low. A beat is
// first registered with its magnitude, square and clip test; from there it is
// folded into the segment accumulators and, when it ends a segment, its result
// is loaded into the output register, which raises out_valid.
// Reset clears accumulators, totals and the known format, and loads default thresholds.
// Input stalls only while a segment-ending beat waits behind a stalled result.
`timescale 1ns / 1ps
`default_nettype none
`include "pcm16_segment_level_qc_assert.svh"

module pcm16_segment_level_qc (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [pslqc_pkg::SMP_W-1:0]     sample,
	input  wire logic                           last_in_segment,
	input  wire logic [pslqc_pkg::RATE_W-1:0]    seg_rate,
	input  wire logic [pslqc_pkg::CH_W-1:0]      channels,
	input  wire logic                           wr_en,
	input  wire logic [pslqc_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [pslqc_pkg::CFG_W-1:0]     wr_data,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic [pslqc_pkg::SMP_W-1:0]     segment_peak,
	output      logic [pslqc_pkg::CLIP_W-1:0]    segment_clipped_samples,
	output      logic [pslqc_pkg::EN_W-1:0]      segment_energy,
	output      logic                           is_silent,
	output      logic                           is_low_peak,
	output      logic                           has_clipping,
	output      logic                           fmt_mismatch,
	output      logic [pslqc_pkg::SMP_W-1:0]     total_peak,
	output      logic [pslqc_pkg::CNT_W-1:0]     total_bad_segments,
	output      logic [pslqc_pkg::CNT_W-1:0]     total_silent_segments,
	output      logic [pslqc_pkg::CNT_W-1:0]     total_low_peak_segments,
	output      logic [pslqc_pkg::CNT_W-1:0]     total_clipped_segments
);
	import pslqc_pkg::*;

	logic [CFG_W-1:0] silent_thr_q;
	logic [CFG_W-1:0] low_thr_q;
	logic [CFG_W-1:0] clip_thr_q;

	beat_t beat_s1;
	logic  valid_s1;
	ctl_t  ctl;
	fig_t  fig_n;
	res_t  res_q;
	logic  accept;
	logic  blocked;

	// Thresholds are to be written by the user only while the block is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silent_thr_q <= SILENT_RST;
			low_thr_q    <= LOWPK_RST;
			clip_thr_q   <= CLIP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SILENT: silent_thr_q <= wr_data;
				REG_LOWPK:  low_thr_q    <= wr_data;
				REG_CLIP:   clip_thr_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Only a segment-ending beat needs the output register; every other beat
	// moves on into the accumulators regardless of the output side.
	assign blocked    = valid_s1 && beat_s1.last && out_valid && out_stall;
	assign ctl.adv    = valid_s1 && !blocked;
	assign ctl.report = ctl.adv && beat_s1.last;
	assign in_stall   = blocked;
	assign accept     = in_valid && !in_stall;

	pslqc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.adv             (ctl.adv),
		.sample          (sample),
		.last_in_segment (last_in_segment),
		.seg_rate        (seg_rate),
		.channels        (channels),
		.clip_thr        (clip_thr_q),
		.beat_s1         (beat_s1),
		.valid_s1        (valid_s1)
	);

	pslqc_seg u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.beat   (beat_s1),
		.fig_n  (fig_n)
	);

	pslqc_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.fig_n      (fig_n),
		.rate       (beat_s1.rate),
		.chans      (beat_s1.chans),
		.silent_thr (silent_thr_q),
		.low_thr    (low_thr_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.res_q      (res_q)
	);

	assign segment_peak            = res_q.segment_peak;
	assign segment_clipped_samples = res_q.segment_clipped_samples;
	assign segment_energy          = res_q.segment_energy;
	assign is_silent               = res_q.is_silent;
	assign is_low_peak             = res_q.is_low_peak;
	assign has_clipping            = res_q.has_clipping;
	assign fmt_mismatch            = res_q.fmt_mismatch;
	assign total_peak              = res_q.total_peak;
	assign total_bad_segments      = res_q.total_bad_segments;
	assign total_silent_segments   = res_q.total_silent_segments;
	assign total_low_peak_segments = res_q.total_low_peak_segments;
	assign total_clipped_segments  = res_q.total_clipped_segments;

	// A new result never overwrites one that is still being held.
	`PSLQC_ASSERT_SAME(a_report_free, ctl.report, !out_valid || !out_stall, "result overwritten")
	`PSLQC_ASSERT_NEXT(a_report_shown, ctl.report, out_valid, "result not presented")
	`PSLQC_ASSERT_SAME(a_stall_cause, in_stall, valid_s1 && beat_s1.last, "spurious input stall")
	`PSLQC_ASSERT_SAME(a_flags_excl, out_valid, !(is_silent && is_low_peak), "silent and low peak")
	`PSLQC_ASSERT_SAME(a_clip_total, out_valid && has_clipping, total_clipped_segments != '0,
		"clipped total missed")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the PCM16 segment level meter and quality check.
// Depends on pslqc_pkg and pcm16_segment_level_qc with the files that it uses.
// A queued driver, a random receiver stall and a predicting monitor do the work.
`timescale 1ns / 1ps

module testbench;

	import pslqc_pkg::*;

	// The first real format that the stream settles on; most segments keep it.
	localparam logic [RATE_W-1:0] FIRST_RATE = 19'd48000;
	localparam logic [CH_W-1:0]   FIRST_CH   = 4'd2;
	localparam logic [CLIP_W-1:0] CLIP_FULL  = {CLIP_W{1'b1}};
	localparam logic [EN_W-1:0]   ENERGY_FULL = {EN_W{1'b1}};
	// Cycles allowed for beats still inside the pipe once the last result is out.
	localparam int unsigned SETTLE_CYCLES = 6;

	typedef enum logic [1:0] {DO_BEAT, DO_WRITE, DO_PAUSE} plan_kind_e;
	typedef enum int unsigned {LV_QUIET, LV_SOFT, LV_LOUD, LV_EDGE, LV_ANY} level_e;

	typedef struct {
		plan_kind_e            kind;
		logic [SMP_W-1:0]      smp;
		logic                  lst;
		logic [RATE_W-1:0]     rate;
		logic [CH_W-1:0]       ch;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      val;
	} plan_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SMP_W-1:0]      sample = '0;
	logic                  last_in_segment = 1'b0;
	logic [RATE_W-1:0]     seg_rate = '0;
	logic [CH_W-1:0]       channels = '0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_W-1:0]      wr_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SMP_W-1:0]      segment_peak;
	logic [CLIP_W-1:0]     segment_clipped_samples;
	logic [EN_W-1:0]       segment_energy;
	logic                  is_silent;
	logic                  is_low_peak;
	logic                  has_clipping;
	logic                  fmt_mismatch;
	logic [SMP_W-1:0]      total_peak;
	logic [CNT_W-1:0]      total_bad_segments;
	logic [CNT_W-1:0]      total_silent_segments;
	logic [CNT_W-1:0]      total_low_peak_segments;
	logic [CNT_W-1:0]      total_clipped_segments;

	pcm16_segment_level_qc DUT (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.sample                  (sample),
		.last_in_segment         (last_in_segment),
		.seg_rate                (seg_rate),
		.channels                (channels),
		.wr_en                   (wr_en),
		.wr_index                (wr_index),
		.wr_data                 (wr_data),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.segment_peak            (segment_peak),
		.segment_clipped_samples (segment_clipped_samples),
		.segment_energy          (segment_energy),
		.is_silent               (is_silent),
		.is_low_peak             (is_low_peak),
		.has_clipping            (has_clipping),
		.fmt_mismatch            (fmt_mismatch),
		.total_peak              (total_peak),
		.total_bad_segments      (total_bad_segments),
		.total_silent_segments   (total_silent_segments),
		.total_low_peak_segments (total_low_peak_segments),
		.total_clipped_segments  (total_clipped_segments)
	);

	// The plan of beats, register writes and pauses, and the segment reports
	// that the meter still owes us, oldest first.
	plan_step_t beat_plan[$];
	res_t       reports_due[$];
	int unsigned mismatch_count = 0;

	// Our own copy of the meter: thresholds as last written, the accumulators
	// of the open segment, the format learnt so far and the running totals.
	logic [CFG_W-1:0]  thr_silent = SILENT_RST;
	logic [CFG_W-1:0]  thr_low    = LOWPK_RST;
	logic [CFG_W-1:0]  thr_clip   = CLIP_RST;
	logic [SMP_W-1:0]  seg_peak   = '0;
	logic [CLIP_W-1:0] seg_clips  = '0;
	logic [EN_W-1:0]   seg_energy = '0;
	logic [RATE_W-1:0] fmt_rate   = '0;
	logic [CH_W-1:0]   fmt_ch     = '0;
	logic [SMP_W-1:0]  top_peak   = '0;
	logic [CNT_W-1:0]  n_bad      = '0;
	logic [CNT_W-1:0]  n_silent   = '0;
	logic [CNT_W-1:0]  n_low      = '0;
	logic [CNT_W-1:0]  n_clipped  = '0;

	// Thresholds as the plan will have them when the next queued beat goes out.
	logic [CFG_W-1:0] plan_silent = SILENT_RST;
	logic [CFG_W-1:0] plan_low    = LOWPK_RST;
	logic [CFG_W-1:0] plan_clip   = CLIP_RST;

	// Driver and receiver bookkeeping.
	logic        in_took = 1'b0;
	logic        wr_pulse;
	int unsigned send_gap = 0;
	int unsigned in_calm = 0;
	int unsigned out_hold = 0;
	int unsigned out_calm = 0;
	int unsigned settle_cnt = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic flag_error(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			flag_error($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
		end
	endtask

	// Folds one accepted beat into the meter copy. A segment-ending beat
	// classifies the segment, updates the totals and queues the report.
	task automatic meter_take(input logic [SMP_W-1:0] smp, input logic lst,
			input logic [RATE_W-1:0] rate, input logic [CH_W-1:0] ch);
		logic [SMP_W-1:0] mag;
		logic [SQ_W-1:0]  sq;
		logic [EN_W+1:0]  sum;
		logic             mism;
		logic             sil;
		logic             lowp;
		logic             clp;
		res_t             rep;
		// Negating 0x8000 in sixteen bits gives 0x8000, which is the 32768 we want.
		mag = smp[SMP_W-1] ? (~smp + 1'b1) : smp;
		sq = {15'd0, mag} * {15'd0, mag};
		if (mag > seg_peak) begin
			seg_peak = mag;
		end
		if (mag >= thr_clip && seg_clips != CLIP_FULL) begin
			seg_clips = seg_clips + 1'b1;
		end
		sum = {2'b00, seg_energy} + {{(EN_W+2-SQ_W){1'b0}}, sq};
		seg_energy = (sum > {2'b00, ENERGY_FULL}) ? ENERGY_FULL : sum[EN_W-1:0];
		if (lst) begin
			// Until a non-zero rate has been seen, each ending segment defines the format.
			if (fmt_rate == '0) begin
				fmt_rate = rate;
				fmt_ch = ch;
			end
			mism = (rate != fmt_rate) || (ch != fmt_ch);
			sil = seg_peak <= thr_silent;
			lowp = !sil && (seg_peak < thr_low);
			clp = seg_clips != '0;
			if (mism && n_bad != '1) n_bad = n_bad + 1'b1;
			if (sil && n_silent != '1) n_silent = n_silent + 1'b1;
			if (lowp && n_low != '1) n_low = n_low + 1'b1;
			if (clp && n_clipped != '1) n_clipped = n_clipped + 1'b1;
			if (seg_peak > top_peak) top_peak = seg_peak;
			rep.segment_peak = seg_peak;
			rep.segment_clipped_samples = seg_clips;
			rep.segment_energy = seg_energy;
			rep.is_silent = sil;
			rep.is_low_peak = lowp;
			rep.has_clipping = clp;
			rep.fmt_mismatch = mism;
			rep.total_peak = top_peak;
			rep.total_bad_segments = n_bad;
			rep.total_silent_segments = n_silent;
			rep.total_low_peak_segments = n_low;
			rep.total_clipped_segments = n_clipped;
			reports_due.push_back(rep);
			seg_peak = '0;
			seg_clips = '0;
			seg_energy = '0;
		end
	endtask

	// Idle length for either side: mostly none or short, now and then long,
	// with occasional calm stretches in which the side never idles at all.
	task automatic draw_idle(inout int unsigned calm, output int unsigned len);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm != 0) begin
			calm--;
			len = 0;
		end else if (r < 4) begin
			calm = $urandom_range(20, 80);
			len = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) len = 0;
			else if (r < 96) len = $urandom_range(1, 3);
			else len = $urandom_range(6, 24);
		end
	endtask

	task automatic queue_beat(input logic [SMP_W-1:0] smp, input logic lst,
			input logic [RATE_W-1:0] rate, input logic [CH_W-1:0] ch);
		plan_step_t s;
		s.kind = DO_BEAT;
		s.smp = smp;
		s.lst = lst;
		s.rate = rate;
		s.ch = ch;
		s.idx = '0;
		s.val = '0;
		beat_plan.push_back(s);
	endtask

	task automatic queue_pause();
		plan_step_t s;
		s.kind = DO_PAUSE;
		s.smp = '0;
		s.lst = 1'b0;
		s.rate = '0;
		s.ch = '0;
		s.idx = '0;
		s.val = '0;
		beat_plan.push_back(s);
	endtask

	// Registers are only touched once the meter has gone quiet, so every
	// change of thresholds is preceded by a full pause.
	task automatic set_thresholds(input logic [CFG_W-1:0] sil, input logic [CFG_W-1:0] low,
			input logic [CFG_W-1:0] clp);
		plan_step_t s;
		queue_pause();
		s.kind = DO_WRITE;
		s.smp = '0;
		s.lst = 1'b0;
		s.rate = '0;
		s.ch = '0;
		s.idx = REG_SILENT;
		s.val = sil;
		beat_plan.push_back(s);
		s.idx = REG_LOWPK;
		s.val = low;
		beat_plan.push_back(s);
		s.idx = REG_CLIP;
		s.val = clp;
		beat_plan.push_back(s);
		plan_silent = sil;
		plan_low = low;
		plan_clip = clp;
	endtask

	// A sample whose magnitude is in the band that the level asks for; the edge
	// level lands within two of a current threshold, or within four of 0 or 32768.
	function automatic logic [SMP_W-1:0] pick_sample(input level_e lv);
		int unsigned mag;
		int unsigned th;
		logic [SMP_W-1:0] v;
		case (lv)
			LV_QUIET: mag = $urandom_range(0, 40);
			LV_SOFT:  mag = $urandom_range(0, 900);
			LV_LOUD:  mag = $urandom_range(32700, 32768);
			LV_EDGE: begin
				case ($urandom_range(0, 2))
					0: th = {16'd0, plan_silent};
					1: th = {16'd0, plan_low};
					default: th = {16'd0, plan_clip};
				endcase
				if (th > 32766) mag = $urandom_range(32764, 32768);
				else if (th < 2) mag = $urandom_range(0, 4);
				else mag = $urandom_range(th - 2, th + 2);
			end
			default: return SMP_W'($urandom);
		endcase
		if (mag == 32768) return 16'h8000;
		v = mag[SMP_W-1:0];
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// Random well-formed segments: the ending beat carries the real format
	// (mostly the first one), the beats before it carry junk format fields.
	task automatic random_phase(input int unsigned n_beats);
		int unsigned done_beats;
		int unsigned len;
		int unsigned r;
		logic [RATE_W-1:0] rate;
		logic [CH_W-1:0]   ch;
		level_e            lv;
		done_beats = 0;
		while (done_beats < n_beats) begin
			r = $urandom_range(0, 99);
			if (r < 80) len = $urandom_range(1, 8);
			else if (r < 95) len = $urandom_range(9, 40);
			else len = $urandom_range(41, 120);
			r = $urandom_range(0, 99);
			rate = FIRST_RATE;
			ch = FIRST_CH;
			if (r >= 80) rate = RATE_W'($urandom_range(1, 524287));
			if (r >= 90) ch = CH_W'($urandom_range(1, 15));
			lv = level_e'($urandom_range(LV_QUIET, LV_ANY));
			for (int i = 0; i < len; i++) begin
				if (i == len - 1) begin
					queue_beat(pick_sample(lv), 1'b1, rate, ch);
				end else begin
					queue_beat(pick_sample($urandom_range(0, 9) == 0 ? LV_ANY : lv), 1'b0,
						RATE_W'($urandom), CH_W'($urandom));
				end
			end
			done_beats += len;
			if ($urandom_range(0, 99) < 3) queue_pause();
		end
	endtask

	// Sender: beats go out at the falling edge and are held until taken.
	always @(negedge clk) begin
		wr_pulse = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_took) begin
				// The beat on the port has not been taken yet and must stay as it is.
			end else if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (beat_plan.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				case (beat_plan[0].kind)
					DO_BEAT: begin
						in_valid <= 1'b1;
						sample <= beat_plan[0].smp;
						last_in_segment <= beat_plan[0].lst;
						seg_rate <= beat_plan[0].rate;
						channels <= beat_plan[0].ch;
						void'(beat_plan.pop_front());
						draw_idle(in_calm, send_gap);
					end
					DO_WRITE: begin
						in_valid <= 1'b0;
						wr_pulse = 1'b1;
						wr_index <= beat_plan[0].idx;
						wr_data <= beat_plan[0].val;
						void'(beat_plan.pop_front());
					end
					default: begin
						// Hold off until every report is in, then let the settle counter
						// run out for beats that end no segment.
						in_valid <= 1'b0;
						if (reports_due.size() != 0) begin
							settle_cnt = 0;
						end else if (settle_cnt >= SETTLE_CYCLES) begin
							settle_cnt = 0;
							void'(beat_plan.pop_front());
						end else begin
							settle_cnt++;
						end
					end
				endcase
			end
		end
		wr_en <= wr_pulse;
	end

	// Receiver: stall at random, in runs of varying length.
	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
			draw_idle(out_calm, out_hold);
		end
	end

	// Monitor: at the rising edge, note register writes, predict on every
	// accepted input beat and check every accepted result beat in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_SILENT: thr_silent = wr_data;
					REG_LOWPK:  thr_low = wr_data;
					REG_CLIP:   thr_clip = wr_data;
					default: ;
				endcase
			end
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				meter_take(sample, last_in_segment, seg_rate, channels);
			end
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					flag_error("result beat with no report outstanding");
				end else begin
					check_field("segment_peak", segment_peak, reports_due[0].segment_peak);
					check_field("segment_clipped_samples", segment_clipped_samples,
						reports_due[0].segment_clipped_samples);
					check_field("segment_energy", segment_energy,
						reports_due[0].segment_energy);
					check_field("is_silent", is_silent, reports_due[0].is_silent);
					check_field("is_low_peak", is_low_peak, reports_due[0].is_low_peak);
					check_field("has_clipping", has_clipping, reports_due[0].has_clipping);
					check_field("fmt_mismatch", fmt_mismatch,
						reports_due[0].fmt_mismatch);
					check_field("total_peak", total_peak, reports_due[0].total_peak);
					check_field("total_bad_segments", total_bad_segments,
						reports_due[0].total_bad_segments);
					check_field("total_silent_segments", total_silent_segments,
						reports_due[0].total_silent_segments);
					check_field("total_low_peak_segments", total_low_peak_segments,
						reports_due[0].total_low_peak_segments);
					check_field("total_clipped_segments", total_clipped_segments,
						reports_due[0].total_clipped_segments);
					void'(reports_due.pop_front());
				end
			end
		end
	end

	initial begin
		// Directed opening. A rate of zero on the first ending beat leaves the
		// format unknown, so the segment after them still learns it.
		queue_beat(16'd0, 1'b1, 19'd0, 4'd3);
		queue_beat(16'h8000, 1'b0, 19'd0, 4'd0);
		queue_beat(16'h7FFF, 1'b0, 19'd0, 4'd0);
		queue_beat(16'd0, 1'b1, FIRST_RATE, FIRST_CH);
		// At and just below the default clip threshold, both signs.
		queue_beat(16'd32759, 1'b0, FIRST_RATE, FIRST_CH);
		queue_beat(16'd32760, 1'b0, FIRST_RATE, FIRST_CH);
		queue_beat(-16'sd32760, 1'b0, FIRST_RATE, FIRST_CH);
		queue_beat(-16'sd32759, 1'b1, FIRST_RATE, FIRST_CH);
		// Just under and at the low peak threshold, each with a format fault.
		queue_beat(16'd699, 1'b0, 19'd0, 4'd0);
		queue_beat(-16'sd699, 1'b1, 19'd44100, FIRST_CH);
		queue_beat(16'd700, 1'b1, FIRST_RATE, 4'd1);
		// At the silent threshold and one above it.
		queue_beat(16'd32, 1'b1, FIRST_RATE, FIRST_CH);
		queue_beat(-16'sd33, 1'b1, FIRST_RATE, FIRST_CH);
		queue_beat(16'd1, 1'b0, FIRST_RATE, FIRST_CH);
		queue_beat(16'hFFFF, 1'b1, 19'h7FFFF, 4'd15);
		queue_beat(16'h5555, 1'b0, 19'h2AAAA, 4'd5);
		queue_beat(16'hAAAA, 1'b1, FIRST_RATE, FIRST_CH);
		queue_beat(16'd100, 1'b0, 19'h2AAAA, 4'd5);
		queue_beat(16'd200, 1'b1, 19'h55555, 4'd10);

		random_phase(180);
		set_thresholds(16'd0, 16'd0, 16'd0);
		random_phase(180);
		set_thresholds(16'd32768, 16'd32768, 16'd32768);
		random_phase(180);
		set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_phase(180);
		set_thresholds(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 5000)),
			CFG_W'($urandom_range(30000, 32768)));
		random_phase(180);
		// Silent threshold above the low one, so no segment can be low peak.
		set_thresholds(16'd1000, 16'd500, 16'd16384);
		random_phase(180);
		// Back to the defaults for a last stretch.
		set_thresholds(SILENT_RST, LOWPK_RST, CLIP_RST);
		random_phase(100);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (beat_plan.size() != 0 || in_valid || reports_due.size() != 0);
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (reports_due.size() != 0) begin
			flag_error($sformatf("%0d reports never arrived", reports_due.size()));
		end
		if (mismatch_count == 0) begin
			$display("** pcm16_segment_level_qc: PASSED **");
		end else begin
			$display("** pcm16_segment_level_qc: FAILED **");
		end
		$finish;
	end

	// Watchdog, set far beyond the slowest legal run of the full plan.
	initial begin
		#2000000;
		$display("** pcm16_segment_level_qc: FAILED **");
		$finish;
	end

endmodule
